// ===== design/ilg_pkg.sv =====
// Package for the intercept and landing guidance block.
// Holds widths, register indexes, opcodes, reset values and the control structs.
// Used by every other file of the block; depends on nothing.
package ilg_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned WIDE_W    = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCEND_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_RADIUS_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_ALT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TOL     = 3'd5;

  // Register reset values (unsigned Q15.16).
  localparam logic [CFG_W-1:0] RST_TRACK_SPEED   = 31'd131072;
  localparam logic [CFG_W-1:0] RST_DESCEND_SPEED = 31'd32768;
  localparam logic [CFG_W-1:0] RST_SOFT_RADIUS   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_SOFT_RADIUS_Z = 31'd655;
  localparam logic [CFG_W-1:0] RST_TAKEOFF_ALT   = 31'd131072;
  localparam logic [CFG_W-1:0] RST_CLOSE_TOL     = 31'd6554;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_VEHICLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TARGET  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  // Multiplier operand selects.
  localparam logic [2:0] MS_DX  = 3'd0;
  localparam logic [2:0] MS_DY  = 3'd1;
  localparam logic [2:0] MS_DZ  = 3'd2;
  localparam logic [2:0] MS_SR  = 3'd3;
  localparam logic [2:0] MS_SRZ = 3'd4;
  localparam logic [2:0] MS_GD  = 3'd5;

  // Norm summation steps.
  localparam logic [1:0] SUM_XY = 2'd0;
  localparam logic [1:0] SUM_Z  = 2'd1;
  localparam logic [1:0] SUM_SD = 2'd2;
  localparam logic [1:0] SUM_SR = 2'd3;

  localparam logic [DATA_W-1:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] I32_MIN = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       tp_write_all;
    logic       tv_div_start;
    logic       tv_write;
    logic [1:0] ax;
    logic       out_takeoff;
    logic       load_d;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       sum_en;
    logic [1:0] sum_step;
    logic       sq_start;
    logic       sq_load;
    logic       sq_dst;
    logic       gd_div_start;
    logic       gd_write;
    logic       out_land;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic dt_zero;
    logic div_done;
    logic sq_done;
    logic den_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ilg_in_if.sv =====
// Input channel interface of the guidance block: valid, ready and one item.
// Depends on ilg_pkg for widths.
interface ilg_in_if;
  logic                              valid;
  logic                              ready;
  logic [ilg_pkg::OP_W-1:0]          op;
  logic signed [ilg_pkg::DATA_W-1:0] pos_x;
  logic signed [ilg_pkg::DATA_W-1:0] pos_y;
  logic signed [ilg_pkg::DATA_W-1:0] pos_z;
  logic [ilg_pkg::CFG_W-1:0]         time_step;

  modport source (output valid, op, pos_x, pos_y, pos_z, time_step, input ready);
  modport sink (input valid, op, pos_x, pos_y, pos_z, time_step, output ready);
endinterface

// ===== design/ilg_out_if.sv =====
// Result channel interface of the guidance block: valid, ready and one setpoint item.
// Depends on ilg_pkg for widths.
interface ilg_out_if;
  logic                              valid;
  logic                              ready;
  logic                              velocity_mode;
  logic signed [ilg_pkg::DATA_W-1:0] cmd_x;
  logic signed [ilg_pkg::DATA_W-1:0] cmd_y;
  logic signed [ilg_pkg::DATA_W-1:0] cmd_z;

  modport source (output valid, velocity_mode, cmd_x, cmd_y, cmd_z, input ready);
  modport sink (input valid, velocity_mode, cmd_x, cmd_y, cmd_z, output ready);
endinterface

// ===== design/ilg_div.sv =====
// Iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on ilg_pkg for widths.
module ilg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ilg_pkg::WIDE_W-1:0]     num,
  input  logic [ilg_pkg::DATA_W-1:0]     den,
  output logic                           done,
  output logic [ilg_pkg::WIDE_W-1:0]     quo
);

  localparam int unsigned CNT_W = $clog2(ilg_pkg::WIDE_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [ilg_pkg::WIDE_W-1:0]  num_r;
  logic [ilg_pkg::DATA_W-1:0]  rem_r;
  logic [ilg_pkg::DATA_W-1:0]  den_r;
  logic [ilg_pkg::DATA_W:0]    rem_sh;
  logic [ilg_pkg::DATA_W:0]    rem_dif;
  logic                        ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_r, num_r[ilg_pkg::WIDE_W-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ilg_pkg::WIDE_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[ilg_pkg::WIDE_W-2:0], ge};
      rem_r <= ge ? rem_dif[ilg_pkg::DATA_W-1:0] : rem_sh[ilg_pkg::DATA_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== design/ilg_sqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits a cycle.
// Depends on ilg_pkg for widths; gives the floor of the root.
module ilg_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ilg_pkg::WIDE_W-1:0] val,
  output logic                       done,
  output logic [ilg_pkg::DATA_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(ilg_pkg::DATA_W);
  localparam int unsigned REM_W = ilg_pkg::DATA_W + 2;

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [ilg_pkg::WIDE_W-1:0] val_r;
  logic [REM_W-1:0]           rem_r;
  logic [ilg_pkg::DATA_W-1:0] root_r;
  logic [REM_W:0]             rem_sh;
  logic [REM_W:0]             trial;
  logic [REM_W:0]             rem_dif;
  logic                       ge;

  // One trial subtraction per root bit.
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], val_r[ilg_pkg::WIDE_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_dif = rem_sh - trial;
    ge      = (rem_sh >= trial);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ilg_pkg::DATA_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Radicand, remainder and partial root.
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[ilg_pkg::WIDE_W-3:0], 2'b00};
      rem_r  <= ge ? rem_dif[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ilg_pkg::DATA_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/ilg_dp.sv =====
// Datapath of the guidance block: registers, state, multiplier, norms and setpoints.
// Depends on ilg_pkg, ilg_div and ilg_sqrt; driven by commands from ilg_ctrl.
module ilg_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ilg_pkg::cmd_t                     cmd,
  output ilg_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [ilg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ilg_pkg::CFG_W-1:0]         cfg_data,
  input  logic [ilg_pkg::OP_W-1:0]          in_op,
  input  logic signed [ilg_pkg::DATA_W-1:0] in_px,
  input  logic signed [ilg_pkg::DATA_W-1:0] in_py,
  input  logic signed [ilg_pkg::DATA_W-1:0] in_pz,
  input  logic [ilg_pkg::CFG_W-1:0]         in_dt,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_vmode,
  output logic signed [ilg_pkg::DATA_W-1:0] out_x,
  output logic signed [ilg_pkg::DATA_W-1:0] out_y,
  output logic signed [ilg_pkg::DATA_W-1:0] out_z
);

  localparam int unsigned DW = ilg_pkg::DATA_W;
  localparam int unsigned WW = ilg_pkg::WIDE_W;
  localparam int unsigned CW = ilg_pkg::CFG_W;
  localparam int unsigned GW = WW + 2;
  localparam int unsigned EW = DW + 2;

  logic [CW-1:0] track_r, descend_r, soft_r, softz_r, alt_r, tol_r;
  logic          mode_r;
  logic          out_valid_r;
  logic          out_vmode_r;
  logic [DW-1:0] out_x_r, out_y_r, out_z_r;

  logic [DW-1:0] veh_r [0:2];
  logic [DW-1:0] tp_r  [0:2];
  logic [DW-1:0] tv_r  [0:2];
  logic [DW-1:0] d_r   [0:2];
  logic [DW-1:0] cres_r [0:2];
  logic [DW-1:0] px_r, py_r, pz_r;
  logic [CW-1:0] dt_r;

  logic [WW-1:0] sq_r [0:4];
  logic [WW-1:0] gd_r, sxy_r, s_r, sz_r;
  logic [DW-1:0] n_r, nz_r;

  logic [DW-1:0] np   [0:2];
  logic [DW-1:0] negz;
  logic [DW-1:0] np_ax, tp_ax, tv_ax, d_ax, veh_d [0:2];
  logic [DW:0]   tdiff;
  logic [DW:0]   tmag;
  logic [DW-1:0] dmag [0:2];
  logic [DW-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;
  logic [DW-1:0] den_sel;
  logic          div_start, div_done, sq_done;
  logic [WW-1:0] div_num, div_quo, sq_val;
  logic [DW-1:0] div_den, sq_root;
  logic [DW-1:0] tv_new;
  logic [GW-1:0] g, gsum;
  logic [DW-1:0] gsat;
  logic [DW:0]   ddiff [0:2];
  logic          close_home, close_tgt;

  // Absolute distance of the vehicle from a point, below tolerance on all axes.
  function automatic logic close3(input logic [DW-1:0] v0, v1, v2,
                                  input logic [EW-1:0] p0, p1, p2,
                                  input logic [CW-1:0] tol);
    logic [EW-1:0] e [0:2];
    logic [EW-1:0] ae;
    logic          ok;
    e[0] = {{2{v0[DW-1]}}, v0} - p0;
    e[1] = {{2{v1[DW-1]}}, v1} - p1;
    e[2] = {{2{v2[DW-1]}}, v2} - p2;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ae = e[i][EW-1] ? (~e[i] + 1'b1) : e[i];
      if (!(ae < {{(EW-CW){1'b0}}, tol})) ok = 1'b0;
    end
    return ok;
  endfunction

  // Remapped target pose: (x, -z saturated, y).
  always_comb begin
    negz  = (pz_r == ilg_pkg::I32_MIN) ? ilg_pkg::I32_MAX : (~pz_r + 1'b1);
    np[0] = px_r;
    np[1] = negz;
    np[2] = py_r;
  end

  // Per-axis selection by the controller's axis.
  always_comb begin
    case (cmd.ax)
      2'd0:    begin np_ax = np[0]; tp_ax = tp_r[0]; tv_ax = tv_r[0]; d_ax = d_r[0]; end
      2'd1:    begin np_ax = np[1]; tp_ax = tp_r[1]; tv_ax = tv_r[1]; d_ax = d_r[1]; end
      default: begin np_ax = np[2]; tp_ax = tp_r[2]; tv_ax = tv_r[2]; d_ax = d_r[2]; end
    endcase
    den_sel = (cmd.ax == 2'd2) ? nz_r : n_r;
  end

  // Target velocity from the divider quotient, saturated to 32 bits.
  always_comb begin
    tdiff = {np_ax[DW-1], np_ax} - {tp_ax[DW-1], tp_ax};
    tmag  = tdiff[DW] ? (~tdiff + 1'b1) : tdiff;
    if (tdiff[DW]) begin
      tv_new = (div_quo >= WW'(64'h8000_0000)) ? ilg_pkg::I32_MIN
                                                : (~div_quo[DW-1:0] + 1'b1);
    end else begin
      tv_new = (div_quo > WW'(64'h7FFF_FFFF)) ? ilg_pkg::I32_MAX : div_quo[DW-1:0];
    end
  end

  // Saturated distances and their magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ddiff[i] = {tp_r[i][DW-1], tp_r[i]} - {veh_r[i][DW-1], veh_r[i]};
      if (ddiff[i][DW] != ddiff[i][DW-1]) begin
        veh_d[i] = ddiff[i][DW] ? ilg_pkg::I32_MIN : ilg_pkg::I32_MAX;
      end else begin
        veh_d[i] = ddiff[i][DW-1:0];
      end
      dmag[i] = d_r[i][DW-1] ? (~d_r[i] + 1'b1) : d_r[i];
    end
  end

  // The one multiplier: squares for the norms and speed times distance.
  always_comb begin
    case (cmd.mul_sel)
      ilg_pkg::MS_DX:  begin mul_a = dmag[0]; mul_b = dmag[0]; end
      ilg_pkg::MS_DY:  begin mul_a = dmag[1]; mul_b = dmag[1]; end
      ilg_pkg::MS_DZ:  begin mul_a = dmag[2]; mul_b = dmag[2]; end
      ilg_pkg::MS_SR:  begin mul_a = {1'b0, soft_r}; mul_b = {1'b0, soft_r}; end
      ilg_pkg::MS_SRZ: begin mul_a = {1'b0, softz_r}; mul_b = {1'b0, softz_r}; end
      default: begin
        mul_a = (cmd.ax == 2'd2) ? {1'b0, descend_r} : {1'b0, track_r};
        case (cmd.ax)
          2'd0:    mul_b = dmag[0];
          2'd1:    mul_b = dmag[1];
          default: mul_b = dmag[2];
        endcase
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Guidance term plus target velocity, saturated.
  always_comb begin
    if (den_sel == '0) begin
      if (d_ax == '0) begin
        g = '0;
      end else begin
        g = d_ax[DW-1] ? {{(GW-DW){1'b1}}, ilg_pkg::I32_MIN}
                       : {{(GW-DW){1'b0}}, ilg_pkg::I32_MAX};
      end
    end else begin
      g = d_ax[DW-1] ? (~{2'b00, div_quo} + 1'b1) : {2'b00, div_quo};
    end
    gsum = g + {{(GW-DW){tv_ax[DW-1]}}, tv_ax};
    if ($signed(gsum) > $signed({{(GW-DW){1'b0}}, ilg_pkg::I32_MAX})) begin
      gsat = ilg_pkg::I32_MAX;
    end else if ($signed(gsum) < $signed({{(GW-DW){1'b1}}, ilg_pkg::I32_MIN})) begin
      gsat = ilg_pkg::I32_MIN;
    end else begin
      gsat = gsum[DW-1:0];
    end
  end

  // Divider and square root operands.
  always_comb begin
    div_start = cmd.tv_div_start | cmd.gd_div_start;
    if (cmd.tv_div_start) begin
      div_num = {15'd0, tmag, 16'd0};
      div_den = {1'b0, dt_r};
    end else begin
      div_num = gd_r;
      div_den = den_sel;
    end
    sq_val = cmd.sq_dst ? sz_r : s_r;
  end

  // Arrival checks.
  always_comb begin
    close_home = close3(veh_r[0], veh_r[1], veh_r[2], '0, '0,
                        {{(EW-CW){1'b0}}, alt_r}, tol_r);
    close_tgt  = close3(veh_r[0], veh_r[1], veh_r[2],
                        {{2{tp_r[0][DW-1]}}, tp_r[0]}, {{2{tp_r[1][DW-1]}}, tp_r[1]},
                        {{2{tp_r[2][DW-1]}}, tp_r[2]}, tol_r);
  end

  ilg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  ilg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Configuration, mode, stored poses and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r     <= ilg_pkg::RST_TRACK_SPEED;
      descend_r   <= ilg_pkg::RST_DESCEND_SPEED;
      soft_r      <= ilg_pkg::RST_SOFT_RADIUS;
      softz_r     <= ilg_pkg::RST_SOFT_RADIUS_Z;
      alt_r       <= ilg_pkg::RST_TAKEOFF_ALT;
      tol_r       <= ilg_pkg::RST_CLOSE_TOL;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        veh_r[i] <= '0;
        tp_r[i]  <= '0;
        tv_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ilg_pkg::CFG_TRACK_SPEED:   track_r   <= cfg_data;
          ilg_pkg::CFG_DESCEND_SPEED: descend_r <= cfg_data;
          ilg_pkg::CFG_SOFT_RADIUS:   soft_r    <= cfg_data;
          ilg_pkg::CFG_SOFT_RADIUS_Z: softz_r   <= cfg_data;
          ilg_pkg::CFG_TAKEOFF_ALT:   alt_r     <= cfg_data;
          ilg_pkg::CFG_CLOSE_TOL:     tol_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_op == ilg_pkg::OP_VEHICLE) begin
        veh_r[0] <= in_px;
        veh_r[1] <= in_py;
        veh_r[2] <= in_pz;
      end
      for (int i = 0; i < 3; i++) begin
        if (cmd.tp_write_all) tp_r[i] <= np[i];
        if (cmd.tv_write && cmd.ax == 2'(i)) begin
          tp_r[i] <= np[i];
          tv_r[i] <= tv_new;
        end
      end
      if (cmd.out_takeoff || cmd.out_land) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.out_takeoff && close_home) mode_r <= 1'b1;
      if (cmd.out_land && close_tgt) mode_r <= 1'b0;
    end
  end

  // Working registers of the tick and the pose latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= in_px;
      py_r <= in_py;
      pz_r <= in_pz;
      dt_r <= in_dt;
    end
    if (cmd.load_d) begin
      for (int i = 0; i < 3; i++) d_r[i] <= veh_d[i];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        ilg_pkg::MS_DX:  sq_r[0] <= mul_p;
        ilg_pkg::MS_DY:  sq_r[1] <= mul_p;
        ilg_pkg::MS_DZ:  sq_r[2] <= mul_p;
        ilg_pkg::MS_SR:  sq_r[3] <= mul_p;
        ilg_pkg::MS_SRZ: sq_r[4] <= mul_p;
        default:         gd_r    <= mul_p;
      endcase
    end
    if (cmd.sum_en) begin
      case (cmd.sum_step)
        ilg_pkg::SUM_XY: sxy_r <= sq_r[0] + sq_r[1];
        ilg_pkg::SUM_Z:  sz_r  <= sxy_r + sq_r[4];
        ilg_pkg::SUM_SD: s_r   <= sxy_r + sq_r[2];
        default:         s_r   <= s_r + sq_r[3];
      endcase
    end
    if (cmd.sq_load) begin
      if (cmd.sq_dst) nz_r <= sq_root;
      else            n_r  <= sq_root;
    end
    if (cmd.gd_write) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.ax == 2'(i)) cres_r[i] <= gsat;
      end
    end
    if (cmd.out_takeoff) begin
      out_vmode_r <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_z_r     <= {1'b0, alt_r};
    end else if (cmd.out_land) begin
      out_vmode_r <= 1'b1;
      out_x_r     <= cres_r[0];
      out_y_r     <= cres_r[1];
      out_z_r     <= cres_r[2];
    end
  end

  always_comb begin
    sts.mode     = mode_r;
    sts.dt_zero  = (dt_r == '0);
    sts.div_done = div_done;
    sts.sq_done  = sq_done;
    sts.den_zero = (den_sel == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_vmode = out_vmode_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

// ===== design/ilg_ctrl.sv =====
// Controller state machine of the guidance block.
// Depends on ilg_pkg; sequences ilg_dp through command and status structs.
module ilg_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [ilg_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  ilg_pkg::sts_t            sts,
  output ilg_pkg::cmd_t            cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TP      = 4'd1;
  localparam logic [3:0] S_TP_WAIT = 4'd2;
  localparam logic [3:0] S_TK0     = 4'd3;
  localparam logic [3:0] S_LD_D    = 4'd4;
  localparam logic [3:0] S_LD_MUL  = 4'd5;
  localparam logic [3:0] S_LD_SUM  = 4'd6;
  localparam logic [3:0] S_SQ      = 4'd7;
  localparam logic [3:0] S_SQ_WAIT = 4'd8;
  localparam logic [3:0] S_AX_MUL  = 4'd9;
  localparam logic [3:0] S_AX_DIV  = 4'd10;
  localparam logic [3:0] S_AX_WAIT = 4'd11;
  localparam logic [3:0] S_AX_WR   = 4'd12;
  localparam logic [3:0] S_LD_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [2:0] k_r, k_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.ax       = ax_r;
    cmd.mul_sel  = k_r;
    cmd.sum_step = k_r[1:0];
    cmd.sq_dst   = k_r[0];
    cmd.accept   = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ax_nxt = 2'd0;
          k_nxt  = 3'd0;
          case (in_op)
            ilg_pkg::OP_TARGET: state_nxt = S_TP;
            ilg_pkg::OP_TICK:   state_nxt = sts.mode ? S_LD_D : S_TK0;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_TP: begin
        if (sts.dt_zero) begin
          cmd.tp_write_all = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.tv_div_start = 1'b1;
          state_nxt        = S_TP_WAIT;
        end
      end
      S_TP_WAIT: begin
        if (sts.div_done) begin
          cmd.tv_write = 1'b1;
          if (ax_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = S_TP;
          end
        end
      end
      S_TK0: begin
        if (sts.out_free) begin
          cmd.out_takeoff = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LD_D: begin
        cmd.load_d = 1'b1;
        state_nxt  = S_LD_MUL;
      end
      // Squares of the three distances and both softening radii.
      S_LD_MUL: begin
        cmd.mul_en = 1'b1;
        if (k_r == ilg_pkg::MS_SRZ) begin
          k_nxt     = 3'd0;
          state_nxt = S_LD_SUM;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_LD_SUM: begin
        cmd.sum_en = 1'b1;
        if (k_r[1:0] == ilg_pkg::SUM_SR) begin
          k_nxt     = 3'd0;
          state_nxt = S_SQ;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // Full norm first, then the vertical norm.
      S_SQ: begin
        cmd.sq_start = 1'b1;
        state_nxt    = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sq_done) begin
          cmd.sq_load = 1'b1;
          if (k_r[0]) begin
            ax_nxt    = 2'd0;
            state_nxt = S_AX_MUL;
          end else begin
            k_nxt     = 3'd1;
            state_nxt = S_SQ;
          end
        end
      end
      S_AX_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ilg_pkg::MS_GD;
        state_nxt   = S_AX_DIV;
      end
      S_AX_DIV: begin
        if (sts.den_zero) begin
          state_nxt = S_AX_WR;
        end else begin
          cmd.gd_div_start = 1'b1;
          state_nxt        = S_AX_WAIT;
        end
      end
      S_AX_WAIT: begin
        if (sts.div_done) state_nxt = S_AX_WR;
      end
      S_AX_WR: begin
        cmd.gd_write = 1'b1;
        if (ax_r == 2'd2) begin
          state_nxt = S_LD_OUT;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = S_AX_MUL;
        end
      end
      S_LD_OUT: begin
        if (sts.out_free) begin
          cmd.out_land = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= 2'd0;
      k_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== design/intercept_landing_guidance.sv =====
// Top level of the intercept and landing guidance block.
// Depends on ilg_pkg, ilg_in_if, ilg_out_if, ilg_ctrl and ilg_dp.
//
//   channel   direction  handshake      carries
//   in_ch     in         valid/ready    op, pos_x, pos_y, pos_z, time_step
//   out_ch    out        valid/ready    velocity_mode, cmd_x, cmd_y, cmd_z
//   cfg_*     in         cfg_we only    cfg_idx, cfg_data
//
// One item is in work at a time. A target pose makes three passes of the 64-step
// divider, one per axis, or none with a zero time step. A land tick runs the 32-step
// square root twice and the divider once for each axis whose norm is not zero.
// Reset is synchronous and active low and needs no clearing pass. A result waits
// in the output register while the next item is accepted; only a tick stalls on it.
module intercept_landing_guidance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ilg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ilg_pkg::CFG_W-1:0]     cfg_data,
  ilg_in_if.sink                        in_ch,
  ilg_out_if.source                     out_ch
);

  ilg_pkg::cmd_t cmd;
  ilg_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  ilg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_op     (in_ch.op),
    .in_px     (in_ch.pos_x),
    .in_py     (in_ch.pos_y),
    .in_pz     (in_ch.pos_z),
    .in_dt     (in_ch.time_step),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_vmode (out_ch.velocity_mode),
    .out_x     (out_ch.cmd_x),
    .out_y     (out_ch.cmd_y),
    .out_z     (out_ch.cmd_z)
  );

endmodule

// ===== test/ilg_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench package: the item and setpoint structs used by the bench.
// Depends on ilg_pkg for widths.
package ilg_tb_pkg;

  // One item of the input channel.
  typedef struct packed {
    logic [ilg_pkg::OP_W-1:0]          op;
    logic signed [ilg_pkg::DATA_W-1:0] px;
    logic signed [ilg_pkg::DATA_W-1:0] py;
    logic signed [ilg_pkg::DATA_W-1:0] pz;
    logic [ilg_pkg::CFG_W-1:0]         dt;
  } pose_item_t;

  // One setpoint result.
  typedef struct packed {
    logic                              vmode;
    logic signed [ilg_pkg::DATA_W-1:0] cx;
    logic signed [ilg_pkg::DATA_W-1:0] cy;
    logic signed [ilg_pkg::DATA_W-1:0] cz;
  } setpoint_t;
endpackage

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for intercept_landing_guidance: directed table, then random pose, tick and unused-op items.
// Setpoints are checked against an in-bench guidance predictor; depends on ilg_pkg and ilg_tb_pkg.
module tb;

  localparam int WATCHDOG = 20000;
  localparam logic [ilg_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ilg_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ilg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ilg_pkg::CFG_W-1:0] cfg_data = '0;

  ilg_in_if in_ch ();
  ilg_out_if out_ch ();

  intercept_landing_guidance uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  longint gd_speed [6];
  bit land_mode;
  longint veh [3];
  longint tgt [3];
  longint tvel [3];

  ilg_tb_pkg::setpoint_t setpoint_q [$];
  int errors = 0;
  int n_checked = 0;
  int n_land = 0;
  int n_items = 0;
  int idle_cycles = 0;
  int rx_cyc = 0;
  bit long_hold = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Guidance term trunc(speed*d/n), saturating when the norm is zero.
  function automatic longint guidance(longint unsigned spd, longint d, longint unsigned n);
    longint unsigned mag;
    longint unsigned q;
    if (n == 0) return (d == 0) ? 0 : (d > 0 ? 64'sd2147483647 : -64'sd2147483648);
    mag = (d < 0) ? -d : d;
    q = (spd * mag) / n;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit near(longint x, longint y, longint z);
    longint p [3];
    longint e;
    p[0] = x; p[1] = y; p[2] = z;
    for (int i = 0; i < 3; i++) begin
      e = veh[i] - p[i];
      if (e < 0) e = -e;
      if (!(e < gd_speed[ilg_pkg::CFG_CLOSE_TOL])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void guidance_reset();
    gd_speed[ilg_pkg::CFG_TRACK_SPEED] = ilg_pkg::RST_TRACK_SPEED;
    gd_speed[ilg_pkg::CFG_DESCEND_SPEED] = ilg_pkg::RST_DESCEND_SPEED;
    gd_speed[ilg_pkg::CFG_SOFT_RADIUS] = ilg_pkg::RST_SOFT_RADIUS;
    gd_speed[ilg_pkg::CFG_SOFT_RADIUS_Z] = ilg_pkg::RST_SOFT_RADIUS_Z;
    gd_speed[ilg_pkg::CFG_TAKEOFF_ALT] = ilg_pkg::RST_TAKEOFF_ALT;
    gd_speed[ilg_pkg::CFG_CLOSE_TOL] = ilg_pkg::RST_CLOSE_TOL;
    land_mode = 1'b0;
    for (int i = 0; i < 3; i++) begin
      veh[i] = 0; tgt[i] = 0; tvel[i] = 0;
    end
  endfunction

  // Advances the predictor by one item; returns 1 and the setpoint for a tick.
  function automatic bit predict_setpoint(ilg_tb_pkg::pose_item_t it,
                                          output ilg_tb_pkg::setpoint_t sp);
    longint np [3];
    longint d [3];
    longint df;
    longint unsigned mag, q, sq [3], nn, nz;
    sp = '0;
    case (it.op)
      ilg_pkg::OP_VEHICLE: begin
        veh[0] = it.px; veh[1] = it.py; veh[2] = it.pz;
        return 1'b0;
      end
      ilg_pkg::OP_TARGET: begin
        np[0] = it.px; np[1] = sat32(-longint'(it.pz)); np[2] = it.py;
        for (int i = 0; i < 3; i++) begin
          if (it.dt != 0) begin
            df = np[i] - tgt[i];
            mag = (df < 0) ? -df : df;
            q = (mag << 16) / it.dt;
            if (q > 64'd2147483648) q = 64'd2147483648;
            tvel[i] = sat32((df < 0) ? -longint'(q) : longint'(q));
          end
          tgt[i] = np[i];
        end
        return 1'b0;
      end
      ilg_pkg::OP_TICK: begin
        if (!land_mode) begin
          sp.cz = 32'(gd_speed[ilg_pkg::CFG_TAKEOFF_ALT]);
          if (near(0, 0, gd_speed[ilg_pkg::CFG_TAKEOFF_ALT])) land_mode = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            d[i] = sat32(tgt[i] - veh[i]);
            mag = (d[i] < 0) ? -d[i] : d[i];
            sq[i] = mag * mag;
          end
          nn = int_sqrt(gd_speed[ilg_pkg::CFG_SOFT_RADIUS] * gd_speed[ilg_pkg::CFG_SOFT_RADIUS]
                        + sq[0] + sq[1] + sq[2]);
          nz = int_sqrt(gd_speed[ilg_pkg::CFG_SOFT_RADIUS_Z]
                        * gd_speed[ilg_pkg::CFG_SOFT_RADIUS_Z] + sq[0] + sq[1]);
          sp.vmode = 1'b1;
          sp.cx = 32'(sat32(guidance(gd_speed[ilg_pkg::CFG_TRACK_SPEED], d[0], nn) + tvel[0]));
          sp.cy = 32'(sat32(guidance(gd_speed[ilg_pkg::CFG_TRACK_SPEED], d[1], nn) + tvel[1]));
          sp.cz = 32'(sat32(guidance(gd_speed[ilg_pkg::CFG_DESCEND_SPEED], d[2], nz)
                            + tvel[2]));
          if (near(tgt[0], tgt[1], tgt[2])) land_mode = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result monitor: compares each accepted setpoint with the oldest expectation.
  always @(posedge clk) begin
    ilg_tb_pkg::setpoint_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (setpoint_q.size() == 0) begin
        report_mismatch("unexpected setpoint", out_ch.cmd_x, 0);
      end else begin
        want = setpoint_q.pop_front();
        n_checked++;
        if (want.vmode) n_land++;
        if (out_ch.velocity_mode !== want.vmode)
          report_mismatch("velocity_mode", out_ch.velocity_mode, want.vmode);
        if (out_ch.cmd_x !== want.cx) report_mismatch("cmd_x", out_ch.cmd_x, want.cx);
        if (out_ch.cmd_y !== want.cy) report_mismatch("cmd_y", out_ch.cmd_y, want.cy);
        if (out_ch.cmd_z !== want.cz) report_mismatch("cmd_z", out_ch.cmd_z, want.cz);
      end
    end
  end

  // Receiver stall pattern, with one long hold-off when requested.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (long_hold) begin
      out_ch.ready <= 1'b0;
      repeat (400) @(posedge clk);
      long_hold = 1'b0;
    end else if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cyc++;
      out_ch.ready <= ($urandom_range(0, 3) != 0) || ((rx_cyc % 64) < 32);
    end
  end

  // Watchdog on cycles where nothing is accepted.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  // One register write; the extra edge keeps back-to-back writes apart in time.
  task automatic write_reg(input logic [ilg_pkg::CFG_IDX_W-1:0] idx, input longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[ilg_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= ilg_pkg::CFG_CLOSE_TOL) gd_speed[idx] = val & 64'h7FFF_FFFF;
    @(posedge clk);
  endtask

  task automatic drain_setpoints();
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Offers one item, holds it until accepted, then updates the predictor.
  task automatic send_item(input ilg_tb_pkg::pose_item_t it);
    ilg_tb_pkg::setpoint_t sp;
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.pos_x <= it.px;
    in_ch.pos_y <= it.py;
    in_ch.pos_z <= it.pz;
    in_ch.time_step <= it.dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (predict_setpoint(it, sp)) setpoint_q.push_back(sp);
  endtask

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [ilg_pkg::DATA_W-1:0] rand_coord(int sel);
    case (sel)
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic ilg_tb_pkg::pose_item_t rand_item();
    ilg_tb_pkg::pose_item_t it;
    int r = $urandom_range(0, 99);
    it.op = (r < 30) ? ilg_pkg::OP_VEHICLE : (r < 55) ? ilg_pkg::OP_TARGET :
            (r < 97) ? ilg_pkg::OP_TICK : OP_UNUSED;
    it.px = rand_coord($urandom_range(0, 12));
    it.py = rand_coord($urandom_range(0, 12));
    it.pz = rand_coord($urandom_range(0, 12));
    r = $urandom_range(0, 9);
    it.dt = (r == 0) ? '0 : (r == 1) ? 31'h7FFF_FFFF :
            (r < 4) ? 31'($urandom) : 31'($urandom_range(1, 1 << 17));
    return it;
  endfunction

  // Sends a well-formed approach: vehicle near hover point, target close by, ticks.
  task automatic send_approach();
    ilg_tb_pkg::pose_item_t it;
    it = '0;
    it.op = ilg_pkg::OP_VEHICLE;
    it.pz = 32'(gd_speed[ilg_pkg::CFG_TAKEOFF_ALT] + $urandom_range(0, 100) - 50);
    send_item(it);
    it.op = ilg_pkg::OP_TICK;
    send_item(it);
    it.op = ilg_pkg::OP_TARGET;
    it.px = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    it.py = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    it.pz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    it.dt = 31'($urandom_range(0, 1 << 16));
    send_item(it);
    repeat ($urandom_range(1, 3)) begin
      it.op = ilg_pkg::OP_TICK;
      send_item(it);
    end
    it.op = ilg_pkg::OP_VEHICLE;
    it.px = 32'(tgt[0] + $urandom_range(0, 200) - 100);
    it.py = 32'(tgt[1] + $urandom_range(0, 200) - 100);
    it.pz = 32'(tgt[2] + $urandom_range(0, 200) - 100);
    send_item(it);
    it.op = ilg_pkg::OP_TICK;
    send_item(it);
  endtask

  ilg_tb_pkg::pose_item_t directed [20];
  ilg_tb_pkg::setpoint_t typed_sp [20];
  bit typed_ok [20];

  initial begin
    ilg_tb_pkg::pose_item_t it;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.time_step = '0;
    guidance_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every op, zero time step, negation saturation.
    foreach (typed_ok[i]) typed_ok[i] = 1'b0;
    directed[0] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    typed_sp[0] = '{1'b0, 0, 0, 131072};
    typed_ok[0] = 1'b1;
    directed[1] = '{ilg_pkg::OP_VEHICLE, 0, 0, 131072, 0};
    directed[2] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    typed_sp[2] = '{1'b0, 0, 0, 131072};
    typed_ok[2] = 1'b1;
    directed[3] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[4] = '{ilg_pkg::OP_TARGET, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                    31'h7FFF_FFFF};
    directed[5] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[6] = '{ilg_pkg::OP_TARGET, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1};
    directed[7] = '{ilg_pkg::OP_TARGET, 65536, 0, 0, 0};
    directed[8] = '{OP_UNUSED, -1, -1, -1, 31'h7FFF_FFFF};
    directed[9] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[10] = '{ilg_pkg::OP_VEHICLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
    directed[11] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[12] = '{ilg_pkg::OP_VEHICLE, 65536, 0, 0, 0};
    directed[13] = '{ilg_pkg::OP_TARGET, 65536, 0, 0, 65536};
    directed[14] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[15] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[16] = '{ilg_pkg::OP_VEHICLE, -1, -1, -1, 0};
    directed[17] = '{ilg_pkg::OP_TARGET, -1, -1, 1, 31'h7FFF_FFFF};
    directed[18] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    directed[19] = '{ilg_pkg::OP_TICK, 0, 0, 0, 0};
    foreach (directed[i]) begin
      send_item(directed[i]);
      if (typed_ok[i] && setpoint_q.size() != 0 && setpoint_q[$] !== typed_sp[i])
        report_mismatch("directed table row", i, 0);
    end
    in_ch.valid <= 1'b0;
    drain_setpoints();

    // Random phases under several register settings, extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(ilg_pkg::CFG_TRACK_SPEED, 0);
          write_reg(ilg_pkg::CFG_DESCEND_SPEED, 0);
          write_reg(ilg_pkg::CFG_SOFT_RADIUS, 0);
          write_reg(ilg_pkg::CFG_SOFT_RADIUS_Z, 0);
          write_reg(ilg_pkg::CFG_TAKEOFF_ALT, 0);
          write_reg(ilg_pkg::CFG_CLOSE_TOL, 0);
        end
        2: begin
          write_reg(ilg_pkg::CFG_TRACK_SPEED, 64'h7FFF_FFFF);
          write_reg(ilg_pkg::CFG_DESCEND_SPEED, 64'h7FFF_FFFF);
          write_reg(ilg_pkg::CFG_SOFT_RADIUS, 64'h7FFF_FFFF);
          write_reg(ilg_pkg::CFG_SOFT_RADIUS_Z, 64'h7FFF_FFFF);
          write_reg(ilg_pkg::CFG_TAKEOFF_ALT, 64'h7FFF_FFFF);
          write_reg(ilg_pkg::CFG_CLOSE_TOL, 64'h7FFF_FFFF);
        end
        default: begin
          for (int r = 0; r <= ilg_pkg::CFG_CLOSE_TOL; r++)
            write_reg(r[ilg_pkg::CFG_IDX_W-1:0], $urandom_range(0, 1 << 18));
          write_reg(ilg_pkg::CFG_CLOSE_TOL, $urandom_range(2000, 20000));
          write_reg(CFG_IDX_NONE, $urandom);
        end
      endcase
      for (int k = 0; k < 36; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          it = rand_item();
          send_item(it);
        end else begin
          send_approach();
        end
        if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 12));
        if (phase == 3 && k == 15) begin
          long_hold = 1'b1;
          repeat (20) begin
            it = '0;
            it.op = ilg_pkg::OP_TICK;
            send_item(it);
          end
        end
        if (phase == 4 && k == 20) begin
          in_ch.valid <= 1'b0;
          while (setpoint_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      drain_setpoints();
    end

    $display("covered %0d items, %0d setpoints checked (%0d in land mode)",
             n_items, n_checked, n_land);
    $display("six register settings including all-zero and all-max");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/ilg_pkg.sv
design/ilg_in_if.sv
design/ilg_out_if.sv
design/ilg_div.sv
design/ilg_sqrt.sv
design/ilg_dp.sv
design/ilg_ctrl.sv
design/intercept_landing_guidance.sv
test/ilg_tb_if.sv
test/tb.sv
